// File: rtl/core/cvd_pkg.sv
package cvd_pkg;

    // Defaults for the top-level parameters
    localparam int TRACEBACK_DEPTH_DEF = 32;
    localparam int SURVIVOR_DEPTH_DEF  = 64;
    localparam int METRIC_WIDTH_DEF    = 16;

    localparam int NUM_STATES = 16;
    localparam int BIAS_W     = 10;
    localparam logic [BIAS_W-1:0] BIAS_RESET = 10'd100;

    // Register map (byte address bit 2 selects the register)
    localparam int  PADDR_W      = 3;
    localparam logic REG_START_BIAS = 1'b0;

    typedef struct packed {
        logic signed [3:0] soft_first;
        logic signed [3:0] soft_second;
        logic              frame_end;
    } t_in;

    typedef struct packed {
        logic decoded_bit;
        logic last_bit;
    } t_out;

endpackage

// File: rtl/core/cvd_ram.sv
module cvd_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/core/conv_k5_rate_half_viterbi_decoder.sv
// Channel   Handshake          Payload   Direction
// input     i_valid/o_ready    i_in      symbol pair in
// output    o_valid/i_ready    o_out     decoded bit out
// config    APB psel/penable   pwdata    start_bias at address 0
//
// An item runs add-compare-select over the state pairs, then a survivor write;
// when it emits, a prefetch state and a serial traceback follow, one survivor
// memory read a step, and the emit state then loads the output register.
// A frame end then streams its bits at one per cycle while i_ready is high.
// Synchronous active-low reset; no clearing pass. Output stalls hold the
// output register and the emit state, which also holds off new input items.
module conv_k5_rate_half_viterbi_decoder
    import cvd_pkg::*;
#(
    parameter int TRACEBACK_DEPTH = TRACEBACK_DEPTH_DEF,
    parameter int SURVIVOR_DEPTH  = SURVIVOR_DEPTH_DEF,
    parameter int METRIC_WIDTH    = METRIC_WIDTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  t_in                i_in,
    output logic               o_valid,
    input  logic               i_ready,
    output t_out               o_out,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    localparam int W  = METRIC_WIDTH;
    localparam int AW = $clog2(SURVIVOR_DEPTH);
    localparam int PW = $clog2(TRACEBACK_DEPTH + 2);
    localparam int KW = $clog2(TRACEBACK_DEPTH + 1);

    localparam logic signed [W+1:0] M_MAX = {3'b000, {(W-1){1'b1}}};
    localparam logic signed [W+1:0] M_MIN = {3'b111, {(W-1){1'b0}}};

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_ACS  = 3'd1;
    localparam logic [2:0] S_SWR  = 3'd2;
    localparam logic [2:0] S_TBP  = 3'd3;
    localparam logic [2:0] S_TB   = 3'd4;
    localparam logic [2:0] S_EMIT = 3'd5;

    // ---------------- configuration ----------------
    logic [BIAS_W-1:0] r_bias;
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_START_BIAS) ? {{(32-BIAS_W){1'b0}}, r_bias} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bias <= BIAS_RESET;
        end else if (psel && penable && pwrite && paddr[2] == REG_START_BIAS) begin
            r_bias <= pwdata[BIAS_W-1:0];
        end
    end

    // ---------------- registers ----------------
    logic [2:0]          r_state;
    logic [3:0]          r_c;          // ACS row counter, data for row r_c-1
    logic                r_bank;       // metric bank holding current metrics
    logic                r_first;      // next item opens a frame
    logic signed [3:0]   r_a, r_b;
    logic                r_last_in;
    logic signed [W-1:0] r_prev_best;
    logic signed [W-1:0] r_run_m;
    logic [3:0]          r_run_i;
    logic signed [W-1:0] r_slo, r_shi;
    logic [15:0]         r_dec;
    logic [AW-1:0]       r_wptr, r_taddr;
    logic [PW-1:0]       r_pend, r_k, r_nsteps, r_cnt;
    logic [3:0]          r_s;
    logic [TRACEBACK_DEPTH:0] r_bits;
    logic                r_flush;
    logic                r_obit;
    logic                r_ov;
    t_out                r_out;

    // ---------------- memories ----------------
    // metric memory row: {states 8+2r+1, 8+2r, 2r+1, 2r}
    logic [2*W-1:0] rd_lo, rd_hi, wd_lo, wd_hi;
    logic [4*W-1:0] rd_pm, wd_pm;
    logic           m_we;
    logic [2:0]     m_waddr, m_raddr;
    logic           sv_we;
    logic [15:0]    sv_rdata;

    cvd_ram #(.WIDTH(4*W), .DEPTH(8)) u_pm (
        .i_clk(i_clk), .i_we(m_we), .i_waddr(m_waddr), .i_wdata(wd_pm),
        .i_raddr(m_raddr), .o_rdata(rd_pm)
    );
    cvd_ram #(.WIDTH(16), .DEPTH(SURVIVOR_DEPTH)) u_surv (
        .i_clk(i_clk), .i_we(sv_we), .i_waddr(r_wptr), .i_wdata(r_dec),
        .i_raddr(r_taddr), .o_rdata(sv_rdata)
    );

    assign rd_lo = rd_pm[2*W-1:0];
    assign rd_hi = rd_pm[4*W-1:2*W];
    assign wd_pm = {wd_hi, wd_lo};

    // ---------------- add-compare-select ----------------
    logic [2:0]          j;
    logic [2*W-1:0]      row;
    logic signed [W-1:0] pm0, pm1, sat_bias, best;
    logic signed [W+1:0] bias_x;
    logic signed [W-1:0] nm_lo, nm_hi;
    logic                d_lo, d_hi;
    logic signed [W-1:0] rb_m1, rb_m2;
    logic [3:0]          rb_i1, rb_i2;

    function automatic logic signed [W+1:0] sat_w(input logic signed [W+1:0] v);
        logic signed [W+1:0] r;
        r = v;
        if (v > M_MAX) r = M_MAX;
        if (v < M_MIN) r = M_MIN;
        return r;
    endfunction

    // new metric and decision for state {bit, j}; predecessors 2j and 2j+1
    function automatic logic [W:0] acs(input logic bit_in, input logic [2:0] jj,
                                        input logic signed [W-1:0] p0,
                                        input logic signed [W-1:0] p1,
                                        input logic signed [W-1:0] bst,
                                        input logic signed [3:0] a,
                                        input logic signed [3:0] b);
        logic signed [5:0]   ax, bx, bm0, bm1;
        logic signed [W+1:0] m0, m1, mm;
        logic                c0, c1, c0p, c1p;
        ax  = 6'(a);
        bx  = 6'(b);
        c0  = bit_in ^ jj[0];
        c1  = bit_in ^ jj[2] ^ jj[0];
        c0p = ~c0;
        c1p = ~c1;
        bm0 = (c0  ? -ax : ax) + (c1  ? -bx : bx);
        bm1 = (c0p ? -ax : ax) + (c1p ? -bx : bx);
        m0  = (W+2)'(p0) - (W+2)'(bst) + (W+2)'(bm0);
        m1  = (W+2)'(p1) - (W+2)'(bst) + (W+2)'(bm1);
        if (m0 > m1) begin
            mm = sat_w(m0);
            return {1'b0, mm[W-1:0]};
        end
        mm = sat_w(m1);
        return {1'b1, mm[W-1:0]};
    endfunction

    always_comb begin
        j        = 3'(r_c - 4'd1);
        row      = j[2] ? rd_hi : rd_lo;
        bias_x   = sat_w({{(W+2-BIAS_W){1'b0}}, r_bias});
        sat_bias = bias_x[W-1:0];
        if (r_first) begin
            pm0  = (j == 3'd0) ? sat_bias : '0;
            pm1  = '0;
            best = sat_bias;
        end else begin
            pm0  = row[W-1:0];
            pm1  = row[2*W-1:W];
            best = r_prev_best;
        end
        {d_lo, nm_lo} = acs(1'b0, j, pm0, pm1, best, r_a, r_b);
        {d_hi, nm_hi} = acs(1'b1, j, pm0, pm1, best, r_a, r_b);
        // running best, lowest index wins ties
        if (j == 3'd0 || nm_lo > r_run_m || (nm_lo == r_run_m && {1'b0, j} < r_run_i)) begin
            rb_m1 = nm_lo;
            rb_i1 = {1'b0, j};
        end else begin
            rb_m1 = r_run_m;
            rb_i1 = r_run_i;
        end
        if (nm_hi > rb_m1 || (nm_hi == rb_m1 && {1'b1, j} < rb_i1)) begin
            rb_m2 = nm_hi;
            rb_i2 = {1'b1, j};
        end else begin
            rb_m2 = rb_m1;
            rb_i2 = rb_i1;
        end
    end

    assign m_raddr = {r_bank, r_c[1:0]};
    assign m_waddr = {~r_bank, j[2:1]};
    assign m_we    = (r_state == S_ACS) && j[0];
    assign wd_lo   = {nm_lo, r_slo};
    assign wd_hi   = {nm_hi, r_shi};
    assign sv_we   = (r_state == S_SWR);

    // ---------------- control ----------------
    logic [PW-1:0] pend_n;
    logic [3:0]    tb_s;
    logic          emit_go;

    assign pend_n  = r_pend + PW'(1);
    assign tb_s    = {r_s[2:0], sv_rdata[r_s]};
    assign emit_go = (r_state == S_EMIT) && (!r_ov || i_ready);
    assign o_ready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_c     <= '0;
            r_bank  <= 1'b0;
            r_first <= 1'b1;
            r_wptr  <= '0;
            r_pend  <= '0;
            r_ov    <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    r_c <= '0;
                    if (i_valid) begin
                        r_a       <= i_in.soft_first;
                        r_b       <= i_in.soft_second;
                        r_last_in <= i_in.frame_end;
                        r_c       <= 4'd1;
                        r_state   <= S_ACS;
                    end
                end
                S_ACS: begin
                    r_dec[{1'b0, j}] <= d_lo;
                    r_dec[{1'b1, j}] <= d_hi;
                    r_run_m <= rb_m2;
                    r_run_i <= rb_i2;
                    if (!j[0]) begin
                        r_slo <= nm_lo;
                        r_shi <= nm_hi;
                    end
                    if (r_c == 4'd8) begin
                        r_state <= S_SWR;
                        r_c     <= '0;
                    end else begin
                        r_c <= r_c + 4'd1;
                    end
                end
                S_SWR: begin
                    r_bank      <= ~r_bank;
                    r_prev_best <= r_run_m;
                    r_s         <= r_run_i;
                    r_taddr     <= r_wptr;
                    r_wptr      <= (r_wptr == AW'(SURVIVOR_DEPTH - 1)) ? '0 : r_wptr + AW'(1);
                    r_k         <= '0;
                    r_first     <= r_last_in;
                    r_flush     <= r_last_in;
                    if (r_last_in) begin
                        r_nsteps <= pend_n;
                        r_pend   <= '0;
                        r_state  <= S_TBP;
                    end else if (pend_n > PW'(TRACEBACK_DEPTH)) begin
                        r_nsteps <= PW'(TRACEBACK_DEPTH);
                        r_pend   <= r_pend;
                        r_state  <= S_TBP;
                    end else begin
                        r_pend  <= pend_n;
                        r_state <= S_IDLE;
                    end
                end
                S_TBP: begin
                    r_taddr <= (r_taddr == '0) ? AW'(SURVIVOR_DEPTH - 1) : r_taddr - AW'(1);
                    r_state <= S_TB;
                end
                S_TB: begin
                    r_bits[r_k[KW-1:0]] <= r_s[3];
                    r_s     <= tb_s;
                    r_k     <= r_k + PW'(1);
                    r_taddr <= (r_taddr == '0) ? AW'(SURVIVOR_DEPTH - 1) : r_taddr - AW'(1);
                    if (r_k == r_nsteps - PW'(1)) begin
                        r_obit  <= tb_s[3];
                        r_cnt   <= r_nsteps - PW'(1);
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (emit_go) begin
                        if (r_flush && r_cnt != '0) begin
                            r_cnt <= r_cnt - PW'(1);
                        end else begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase

            // output register: load a new transfer or drop the taken one
            if (emit_go) begin
                r_ov <= 1'b1;
            end else if (r_ov && i_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit_go) begin
            if (r_flush) begin
                r_out.decoded_bit <= r_bits[r_cnt[KW-1:0]];
                r_out.last_bit    <= (r_cnt == '0);
            end else begin
                r_out.decoded_bit <= r_obit;
                r_out.last_bit    <= 1'b0;
            end
        end
    end

    assign o_valid = r_ov;
    assign o_out   = r_out;

`ifndef SYNTHESIS
    a_pend_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend <= PW'(TRACEBACK_DEPTH))
        else $error("pending count beyond traceback window");
    a_wptr_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SWR) |=> (r_wptr != $past(r_wptr)))
        else $error("survivor pointer did not advance");
    a_accept_acs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> (r_state == S_ACS))
        else $error("accepted item did not start ACS");
`endif

endmodule

// File: tb/sv/conv_k5_rate_half_viterbi_decoder_tb.sv
module conv_k5_rate_half_viterbi_decoder_tb;
    import cvd_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int TB_DEPTH = TRACEBACK_DEPTH_DEF;
    localparam int SV_DEPTH = SURVIVOR_DEPTH_DEF;
    localparam int MW       = METRIC_WIDTH_DEF;
    localparam int CYCLE_LIMIT = 900000;
    // Worst-case drain per item: ACS, traceback, then a flush stream under stall.
    localparam int SETTLE_CYCLES = 4 * (10 + TB_DEPTH + 2);

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_ready;
    t_in                i_in;
    logic               o_valid;
    logic               i_ready;
    t_out               o_out;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;

    conv_k5_rate_half_viterbi_decoder dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_in    (i_in),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_out   (o_out),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // ------------------------------------------------------------------
    // Decoder model: own copy of metrics, survivors and counters.
    // ------------------------------------------------------------------
    logic [BIAS_W-1:0]       bias_reg;
    longint                  pm [NUM_STATES];
    logic [NUM_STATES-1:0]   surv [SV_DEPTH];
    int unsigned             steps_in_frame;
    int unsigned             bits_out;
    int unsigned             surv_wr;

    t_in  symbol_queue [$];   // pending symbol pairs for the driver
    t_out bit_queue    [$];   // decoded bits still to arrive

    int unsigned cycle_cnt;
    int unsigned errors;
    int unsigned frames_done;
    int unsigned bits_checked;
    int unsigned symbols_sent;
    bit          idle_stretch;   // no random idling when set

    function automatic longint clamp_metric(longint v);
        longint hi;
        hi = (longint'(1) << (MW - 1)) - 1;
        if (v > hi) return hi;
        if (v < -hi - 1) return -hi - 1;
        return v;
    endfunction

    function automatic int unsigned top_state();
        int unsigned b;
        b = 0;
        for (int n = 1; n < NUM_STATES; n++)
            if (pm[n] > pm[b]) b = n;
        return b;
    endfunction

    task automatic frame_metrics_init();
        for (int n = 0; n < NUM_STATES; n++) pm[n] = 0;
        pm[0] = clamp_metric(longint'(bias_reg));
    endtask

    function automatic int unsigned trace_back(int unsigned s, int unsigned slot);
        logic d;
        d = surv[slot % SV_DEPTH][s];
        return ((s << 1) & 15) | d;
    endfunction

    task automatic decode_symbol(t_in sym);
        int a, b, bm;
        longint best;
        longint cand [2];
        longint nm [NUM_STATES];
        logic [NUM_STATES-1:0] dec;
        int unsigned prev, c0, c1, bit_in, slot, pending, s;
        bit bits [TB_DEPTH+1];
        t_out r;

        a = sym.soft_first;
        b = sym.soft_second;
        if (steps_in_frame == 0) frame_metrics_init();
        best = pm[top_state()];
        dec = '0;
        for (int n = 0; n < NUM_STATES; n++) begin
            bit_in = n >> 3;
            for (int p = 0; p < 2; p++) begin
                prev = ((n << 1) & 15) | p;
                c0 = bit_in ^ ((prev >> 1) & 1) ^ (prev & 1);
                c1 = bit_in ^ ((prev >> 3) & 1) ^ ((prev >> 1) & 1) ^ (prev & 1);
                bm = (c0 ? -a : a) + (c1 ? -b : b);
                cand[p] = pm[prev] - best + bm;
            end
            // ties go to the predecessor with low bit set
            if (cand[0] > cand[1]) begin
                nm[n] = clamp_metric(cand[0]);
            end else begin
                nm[n] = clamp_metric(cand[1]);
                dec[n] = 1'b1;
            end
        end
        for (int n = 0; n < NUM_STATES; n++) pm[n] = nm[n];
        slot = surv_wr;
        surv[slot] = dec;
        surv_wr = (surv_wr + 1) % SV_DEPTH;
        steps_in_frame = (steps_in_frame + 1) & 16'hffff;
        pending = (steps_in_frame - bits_out) & 16'hffff;
        if (pending > TB_DEPTH + 1) pending = TB_DEPTH + 1;

        if (sym.frame_end) begin
            s = top_state();
            for (int k = 0; k < pending; k++) begin
                bits[pending-1-k] = 1'(s >> 3);
                s = trace_back(s, slot + 2 * SV_DEPTH - k);
            end
            for (int k = 0; k < pending; k++) begin
                r.decoded_bit = bits[k];
                r.last_bit    = (k + 1 == pending);
                bit_queue.push_back(r);
            end
            frame_metrics_init();
            steps_in_frame = 0;
            bits_out = 0;
        end else if (pending > TB_DEPTH) begin
            s = top_state();
            for (int k = 0; k + 1 < pending; k++)
                s = trace_back(s, slot + 2 * SV_DEPTH - k);
            r.decoded_bit = 1'(s >> 3);
            r.last_bit    = 1'b0;
            bit_queue.push_back(r);
            bits_out = (bits_out + 1) & 16'hffff;
        end
    endtask

    // ------------------------------------------------------------------
    // Clock, cycle counter and timeout
    // ------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d bits outstanding",
                     cycle_cnt, bit_queue.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Symbol driver: one transfer per accepted pair; valid holds until taken.
    // The model is stepped at acceptance so config changes land in order.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready) begin
                decode_symbol(i_in);
                symbols_sent <= symbols_sent + 1;
            end
            if (!i_valid || o_ready) begin
                if (symbol_queue.size() != 0 &&
                        (idle_stretch || $urandom_range(99) >= 31)) begin
                    i_in    <= symbol_queue.pop_front();
                    i_valid <= 1'b1;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Bit monitor: compare each transfer with the oldest expected bit.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                if (bit_queue.size() == 0) begin
                    $error("unexpected bit transfer %b/%b", o_out.decoded_bit,
                           o_out.last_bit);
                    errors++;
                end else begin
                    t_out want;
                    want = bit_queue.pop_front();
                    if (o_out.decoded_bit !== want.decoded_bit) begin
                        $error("decoded_bit: expected %b, got %b",
                               want.decoded_bit, o_out.decoded_bit);
                        errors++;
                    end
                    if (o_out.last_bit !== want.last_bit) begin
                        $error("last_bit: expected %b, got %b",
                               want.last_bit, o_out.last_bit);
                        errors++;
                    end
                    if (want.last_bit) frames_done++;
                    bits_checked++;
                end
            end
            i_ready <= idle_stretch || ($urandom_range(99) >= 31);
        end
    end

    // ------------------------------------------------------------------
    // APB register write: setup then access phase.
    // ------------------------------------------------------------------
    task automatic write_bias(logic [BIAS_W-1:0] v);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_START_BIAS, 2'b00};
        pwdata  <= 32'(v);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        bias_reg = v;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    function automatic t_in make_sym(int a, int b, bit fe);
        t_in t;
        t.soft_first  = a[3:0];
        t.soft_second = b[3:0];
        t.frame_end   = fe;
        return t;
    endfunction

    // Encode random info bits and add noise; about one pair in ten is replaced by raw random soft values.
    task automatic queue_frame(int unsigned len, int unsigned noise);
        int unsigned st, bi, c0, c1, nxt;
        int a, b;
        st = 0;
        for (int i = 0; i < len; i++) begin
            bi = (i >= len - 4) ? 0 : $urandom_range(1);
            nxt = (st >> 1) | (bi << 3);
            // first: 1+D3+D4, second: 1+D+D3+D4
            c0 = bi ^ ((st >> 1) & 1) ^ (st & 1);
            c1 = bi ^ ((st >> 3) & 1) ^ ((st >> 1) & 1) ^ (st & 1);
            st = nxt;
            a = c0 ? -6 : 6;
            b = c1 ? -6 : 6;
            a += $urandom_range(2 * noise) - int'(noise);
            b += $urandom_range(2 * noise) - int'(noise);
            if ($urandom_range(9) == 0) begin
                a = $urandom_range(15) - 8;
                b = $urandom_range(15) - 8;
            end
            a = (a > 7) ? 7 : (a < -8) ? -8 : a;
            b = (b > 7) ? 7 : (b < -8) ? -8 : b;
            symbol_queue.push_back(make_sym(a, b, i == len - 1));
        end
    endtask

    task automatic drain();
        while (!(symbol_queue.size() == 0 && !i_valid && bit_queue.size() == 0))
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        int unsigned len;
        i_rst_n      = 1'b0;
        i_valid      = 1'b0;
        i_ready      = 1'b0;
        i_in         = '0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        cycle_cnt    = 0;
        errors       = 0;
        frames_done  = 0;
        bits_checked = 0;
        symbols_sent = 0;
        idle_stretch = 1'b0;
        bias_reg       = BIAS_RESET;
        steps_in_frame = 0;
        bits_out       = 0;
        surv_wr        = 0;
        frame_metrics_init();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: single-item frame, then a short frame of soft extremes that is
        // decoded only at its flush.
        symbol_queue.push_back(make_sym(-8, 7, 1'b1));
        symbol_queue.push_back(make_sym(7, -8, 1'b0));
        symbol_queue.push_back(make_sym(0, 0, 1'b0));
        symbol_queue.push_back(make_sym(-8, -8, 1'b0));
        symbol_queue.push_back(make_sym(7, 7, 1'b0));
        symbol_queue.push_back(make_sym(-1, 1, 1'b1));
        drain();

        // Bias extremes; ties among all-zero starts with bias 0.
        write_bias('0);
        for (int i = 0; i < 5; i++) symbol_queue.push_back(make_sym(0, 0, i == 4));
        drain();
        write_bias(10'h3ff);
        queue_frame(40, 0);   // crosses the traceback window
        drain();

        // Random frames, mostly well-formed codewords with noise.
        for (int ph = 0; ph < 4; ph++) begin
            write_bias(10'($urandom_range(1023)));
            idle_stretch = (ph == 2);
            repeat (4) begin
                len = ($urandom_range(3) == 0) ? $urandom_range(70, 34)
                                                : $urandom_range(20, 1);
                queue_frame(len, $urandom_range(6));
            end
            drain();
        end
        idle_stretch = 1'b0;
        write_bias(BIAS_RESET);
        queue_frame(70, 3);
        queue_frame(3, 8);
        drain();

        $display("covered %0d symbol pairs in %0d frames, %0d bits checked",
                 symbols_sent, frames_done, bits_checked);
        if (errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// File: sim.f
rtl/core/cvd_pkg.sv
rtl/core/cvd_ram.sv
rtl/core/conv_k5_rate_half_viterbi_decoder.sv
tb/sv/conv_k5_rate_half_viterbi_decoder_tb.sv
